[hw/rtl/pvoc_pkg.sv]
// Shared types, constants and arctangent table for the polar offset corrector.
`default_nettype none

package pvoc_pkg;

   localparam int XY_W     = 34;  // x/y datapath, 8 guard bits below the I/O LSB
   localparam int Z_W      = 32;  // angle accumulator, 2^32 units per turn
   localparam int MAG_W    = 20;
   localparam int ANG_W    = 16;
   localparam int DELTA_W  = 21;
   localparam int CMAG_W   = 22;
   localparam int GUARD    = 8;
   localparam int ATAN_LEN = 24;

   localparam logic [29:0] INV_GAIN = 30'd652032874;  // 1/K in Q30

   localparam logic signed [ANG_W-1:0] QUARTER_POS = 16'sd16384;
   localparam logic signed [ANG_W-1:0] QUARTER_NEG = -16'sd16384;

   typedef struct packed {
      logic signed [XY_W-1:0]    x;
      logic signed [XY_W-1:0]    y;
      logic [Z_W-1:0]            z;
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic                      zero;
   } cordic_beat_type;

   // atan(2^-idx) in 2^32-per-turn units, rounded to nearest
   function automatic logic [Z_W-1:0] atan_at(input int idx);
      logic [Z_W-1:0] val;
      unique case (idx)
         0:       val = 32'd536870912;
         1:       val = 32'd316933406;
         2:       val = 32'd167458907;
         3:       val = 32'd85004756;
         4:       val = 32'd42667331;
         5:       val = 32'd21354465;
         6:       val = 32'd10679838;
         7:       val = 32'd5340245;
         8:       val = 32'd2670163;
         9:       val = 32'd1335087;
         10:      val = 32'd667544;
         11:      val = 32'd333772;
         12:      val = 32'd166886;
         13:      val = 32'd83443;
         14:      val = 32'd41722;
         15:      val = 32'd20861;
         16:      val = 32'd10430;
         17:      val = 32'd5215;
         18:      val = 32'd2608;
         19:      val = 32'd1304;
         20:      val = 32'd652;
         21:      val = 32'd326;
         22:      val = 32'd163;
         23:      val = 32'd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/pvoc_cell.sv]
// One CORDIC micro-rotation cell with its own pipeline register and handshake.
`default_nettype none

module pvoc_cell
   import pvoc_pkg::*;
#(
   parameter int STEP      = 0,
   parameter bit VECTORING = 1'b0
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire cordic_beat_type in_beat,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output cordic_beat_type      out_beat
);

   localparam logic [Z_W-1:0] ATAN = atan_at(STEP);

   logic                    valid_ff;
   cordic_beat_type         beat_ff;
   cordic_beat_type         beat_in;
   logic                    turn_neg;
   logic signed [XY_W-1:0]  x_sh;
   logic signed [XY_W-1:0]  y_sh;

   always_comb begin
      beat_in = in_beat;
      x_sh    = in_beat.x >>> STEP;
      y_sh    = in_beat.y >>> STEP;
      // rotation steers on the residual angle, vectoring on the sign of y
      if (VECTORING) begin
         turn_neg = in_beat.y[XY_W-1];
      end else begin
         turn_neg = !in_beat.z[Z_W-1];
      end
      if (turn_neg) begin
         beat_in.x = in_beat.x - y_sh;
         beat_in.y = in_beat.y + x_sh;
         beat_in.z = in_beat.z - ATAN;
      end else begin
         beat_in.x = in_beat.x + y_sh;
         beat_in.y = in_beat.y - x_sh;
         beat_in.z = in_beat.z + ATAN;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         beat_ff <= beat_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/polar_vector_offset_correction.sv]
// Top level: polar-to-rectangular CORDIC, offset add, rectangular-to-polar CORDIC.
// Throughput: one beat per cycle unless rsp_ready stalls;
// every stage is a register with its own valid bit.
// A stalled result backs up stage by stage, and bubbles in the chain are squeezed out.
// Two gain-correction multipliers and one magnitude multiplier set the stage timing.
// Reset (synchronous) empties the pipeline; no other state is held.
`default_nettype none

module polar_vector_offset_correction
   import pvoc_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [MAG_W-1:0]           req_magnitude,
   input  wire logic signed [ANG_W-1:0]    req_angle,
   input  wire logic signed [DELTA_W-1:0]  req_delta_x,
   input  wire logic signed [DELTA_W-1:0]  req_delta_y,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [CMAG_W-1:0]               rsp_corrected_magnitude,
   output logic signed [ANG_W-1:0]         rsp_corrected_angle
);

   localparam int NSTEP = (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS : ATAN_LEN;

   // ---------------- pre-rotation stage ----------------
   logic             p_valid_ff;
   logic             p_ready;
   cordic_beat_type  p_beat_ff;
   cordic_beat_type  p_beat_in;
   logic [XY_W-1:0]  p_mag_ext;

   always_comb begin
      p_mag_ext = {{(XY_W - MAG_W - GUARD){1'b0}}, req_magnitude, {GUARD{1'b0}}};
      p_beat_in      = '0;
      p_beat_in.dx   = req_delta_x;
      p_beat_in.dy   = req_delta_y;
      // outside +-pi/2: flip x and move the angle by half a turn (bit 15 toggles)
      if (req_angle > QUARTER_POS || req_angle < QUARTER_NEG) begin
         p_beat_in.x = -$signed(p_mag_ext);
         p_beat_in.z = {req_angle ^ 16'h8000, 16'h0000};
      end else begin
         p_beat_in.x = $signed(p_mag_ext);
         p_beat_in.z = {req_angle, 16'h0000};
      end
   end

   // ---------------- rotation chain ----------------
   logic            rot_valid [NSTEP+1];
   logic            rot_ready [NSTEP+1];
   cordic_beat_type rot_beat  [NSTEP+1];

   assign p_ready      = !p_valid_ff || rot_ready[0];
   assign req_ready    = p_ready;
   assign rot_valid[0] = p_valid_ff;
   assign rot_beat[0]  = p_beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (p_ready) begin
         p_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (p_ready && req_valid) begin
         p_beat_ff <= p_beat_in;
      end
   end

   for (genvar k = 0; k < NSTEP; k++) begin : g_rot
      pvoc_cell #(
         .STEP      (k),
         .VECTORING (1'b0)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (rot_valid[k]),
         .in_ready  (rot_ready[k]),
         .in_beat   (rot_beat[k]),
         .out_valid (rot_valid[k+1]),
         .out_ready (rot_ready[k+1]),
         .out_beat  (rot_beat[k+1])
      );
   end

   // ---------------- gain correction multiply ----------------
   logic                      g_valid_ff;
   logic                      g_ready;
   logic signed [62:0]        g_px_ff;
   logic signed [62:0]        g_py_ff;
   logic signed [62:0]        g_px_in;
   logic signed [62:0]        g_py_in;
   logic signed [DELTA_W-1:0] g_dx_ff;
   logic signed [DELTA_W-1:0] g_dy_ff;
   logic signed [31:0]        g_xa;
   logic signed [31:0]        g_ya;
   logic signed [30:0]        g_k;

   assign g_xa    = rot_beat[NSTEP].x[31:0];
   assign g_ya    = rot_beat[NSTEP].y[31:0];
   assign g_k     = $signed({1'b0, INV_GAIN});
   assign g_px_in = g_xa * g_k;
   assign g_py_in = g_ya * g_k;

   assign rot_ready[NSTEP] = g_ready;

   // ---------------- offset add ----------------
   logic                   o_valid_ff;
   logic                   o_ready;
   logic signed [XY_W-1:0] o_x_ff;
   logic signed [XY_W-1:0] o_y_ff;
   logic signed [62:0]     o_sx;
   logic signed [62:0]     o_sy;
   logic signed [62:0]     o_rnd;

   assign g_ready = !g_valid_ff || o_ready;
   assign o_rnd   = 63'sd536870912;  // half LSB of the Q30 product

   // the offset is folded into the rounding add: dx<<8 after >>30 is dx<<38 before
   assign o_sx = g_px_ff + o_rnd + $signed({g_dx_ff, 38'd0});
   assign o_sy = g_py_ff + o_rnd + $signed({g_dy_ff, 38'd0});

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (g_ready) begin
         g_valid_ff <= rot_valid[NSTEP];
      end
   end

   always_ff @(posedge clock) begin
      if (g_ready && rot_valid[NSTEP]) begin
         g_px_ff <= g_px_in;
         g_py_ff <= g_py_in;
         g_dx_ff <= rot_beat[NSTEP].dx;
         g_dy_ff <= rot_beat[NSTEP].dy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (o_ready) begin
         o_valid_ff <= g_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (o_ready && g_valid_ff) begin
         o_x_ff <= {o_sx[62], o_sx[62:30]};
         o_y_ff <= {o_sy[62], o_sy[62:30]};
      end
   end

   // ---------------- vectoring prep ----------------
   logic            v_valid_ff;
   logic            v_ready;
   cordic_beat_type v_beat_ff;
   cordic_beat_type v_beat_in;

   always_comb begin
      v_beat_in      = '0;
      v_beat_in.zero = (o_x_ff == '0) && (o_y_ff == '0);
      if (o_x_ff[XY_W-1]) begin
         v_beat_in.x = -o_x_ff;
         v_beat_in.y = -o_y_ff;
         v_beat_in.z = 32'h8000_0000;
      end else begin
         v_beat_in.x = o_x_ff;
         v_beat_in.y = o_y_ff;
         v_beat_in.z = '0;
      end
   end

   assign o_ready = !o_valid_ff || v_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_valid_ff <= 1'b0;
      end else if (v_ready) begin
         v_valid_ff <= o_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (v_ready && o_valid_ff) begin
         v_beat_ff <= v_beat_in;
      end
   end

   // ---------------- vectoring chain ----------------
   logic            vec_valid [NSTEP+1];
   logic            vec_ready [NSTEP+1];
   cordic_beat_type vec_beat  [NSTEP+1];

   assign v_ready      = !v_valid_ff || vec_ready[0];
   assign vec_valid[0] = v_valid_ff;
   assign vec_beat[0]  = v_beat_ff;

   for (genvar k = 0; k < NSTEP; k++) begin : g_vec
      pvoc_cell #(
         .STEP      (k),
         .VECTORING (1'b1)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vec_valid[k]),
         .in_ready  (vec_ready[k]),
         .in_beat   (vec_beat[k]),
         .out_valid (vec_valid[k+1]),
         .out_ready (vec_ready[k+1]),
         .out_beat  (vec_beat[k+1])
      );
   end

   // ---------------- magnitude gain multiply ----------------
   logic             m_valid_ff;
   logic             m_ready;
   logic [61:0]      m_prod_ff;
   logic [Z_W-1:0]   m_z_ff;
   logic             m_zero_ff;
   logic [31:0]      m_xa;

   // x stays non-negative through vectoring and below 2^31
   assign m_xa = vec_beat[NSTEP].x[31:0];

   assign vec_ready[NSTEP] = m_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (m_ready) begin
         m_valid_ff <= vec_valid[NSTEP];
      end
   end

   always_ff @(posedge clock) begin
      if (m_ready && vec_valid[NSTEP]) begin
         m_prod_ff <= m_xa * INV_GAIN;
         m_z_ff    <= vec_beat[NSTEP].z;
         m_zero_ff <= vec_beat[NSTEP].zero;
      end
   end

   // ---------------- round, saturate, output register ----------------
   logic               f_valid_ff;
   logic               f_ready;
   logic [CMAG_W-1:0]  f_mag_ff;
   logic [ANG_W-1:0]   f_ang_ff;
   logic [CMAG_W-1:0]  f_mag_in;
   logic [ANG_W-1:0]   f_ang_in;
   logic [62:0]        f_sum;
   logic [Z_W-1:0]     f_zr;

   always_comb begin
      f_sum = {1'b0, m_prod_ff} + 63'h20_0000_0000;  // + 2^37
      f_zr  = m_z_ff + 32'h0000_8000;
      if (m_zero_ff) begin
         f_mag_in = '0;
         f_ang_in = '0;
      end else begin
         f_ang_in = f_zr[Z_W-1:Z_W-ANG_W];
         if (f_sum[62:60] != 3'b000) begin
            f_mag_in = '1;
         end else begin
            f_mag_in = f_sum[59:38];
         end
      end
   end

   assign m_ready   = !m_valid_ff || f_ready;
   assign f_ready   = !f_valid_ff || rsp_ready;
   assign rsp_valid = f_valid_ff;
   assign rsp_corrected_magnitude = f_mag_ff;
   assign rsp_corrected_angle     = $signed(f_ang_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (f_ready) begin
         f_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (f_ready && m_valid_ff) begin
         f_mag_ff <= f_mag_in;
         f_ang_ff <= f_ang_in;
      end
   end

   // ---------------- assertions ----------------
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid && !p_valid_ff && !m_valid_ff)
      else $error("pipeline not empty after reset");

   a_pre_holds: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff && !rot_ready[0] |=> p_valid_ff && $stable(p_beat_ff))
      else $error("pre-rotation stage lost or changed a stalled beat");

   a_gain_holds: assert property (@(posedge clock) disable iff (reset)
      g_valid_ff && !o_ready |=> g_valid_ff && $stable(g_px_ff) && $stable(g_py_ff))
      else $error("gain stage lost or changed a stalled beat");

   a_mag_holds: assert property (@(posedge clock) disable iff (reset)
      m_valid_ff && !f_ready |=> m_valid_ff && $stable(m_prod_ff) && $stable(m_z_ff))
      else $error("magnitude stage lost or changed a stalled beat");

endmodule

`default_nettype wire

[dv/polar_vector_offset_correction_tb.sv]
// Testbench for the polar vector offset corrector: random and directed beats checked in order.
`timescale 1ns / 1ps

module polar_vector_offset_correction_tb;
   import pvoc_pkg::*;

   localparam int     ITERATIONS   = 16;
   localparam int     STEPS        = (ITERATIONS < ATAN_LEN) ? ITERATIONS : ATAN_LEN;
   localparam int     LATENCY      = 2 * STEPS + 6;
   localparam int     RANDOM_BEATS = 1830;
   localparam int     QUIET_TAIL   = 200;
   localparam int     HOLD_START   = 1500;
   localparam int     HOLD_CYCLES  = 200;
   localparam longint GAIN_Q30     = 64'sd652032874;
   localparam longint XY_ROUND     = 64'sd536870912;    // half LSB before >>> 30
   localparam longint MAG_ROUND    = 64'sd137438953472; // half LSB before >>> 38
   localparam longint CMAG_MAX     = 64'sd4194303;
   localparam int     MAG_MAX      = 1048575;
   localparam int     DELTA_MAX    = 1048575;
   localparam int     DELTA_MIN    = -1048576;

   typedef struct packed {
      logic [MAG_W-1:0]          magnitude;
      logic signed [ANG_W-1:0]   angle;
      logic signed [DELTA_W-1:0] delta_x;
      logic signed [DELTA_W-1:0] delta_y;
      logic                      drain_first;   // hold this beat until all results are back
   } polar_request_type;

   typedef struct packed {
      logic [CMAG_W-1:0]       magnitude;
      logic signed [ANG_W-1:0] angle;
   } polar_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [MAG_W-1:0]          req_magnitude = '0;
   logic signed [ANG_W-1:0]   req_angle = '0;
   logic signed [DELTA_W-1:0] req_delta_x = '0;
   logic signed [DELTA_W-1:0] req_delta_y = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [CMAG_W-1:0]         rsp_corrected_magnitude;
   logic signed [ANG_W-1:0]   rsp_corrected_angle;

   polar_request_type pending_requests[$];
   polar_result_type  expected_polar[$];
   polar_request_type in_flight;
   polar_result_type  want;
   int             total_requests = 0;
   int             requests_sent = 0;
   int             results_seen = 0;
   int             mismatches = 0;
   int             send_gap = 0;
   int             stall_left = 0;
   int             hold_left = 0;
   int             rx_cycles = 0;

   polar_vector_offset_correction #(
      .CORDIC_ITERATIONS(ITERATIONS)
   ) uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_magnitude          (req_magnitude),
      .req_angle              (req_angle),
      .req_delta_x            (req_delta_x),
      .req_delta_y            (req_delta_y),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_corrected_magnitude(rsp_corrected_magnitude),
      .rsp_corrected_angle    (rsp_corrected_angle)
   );

   always #2 clock = ~clock;

   // atan(2^-k), 2^32 units per turn
   function automatic longint arctan_step(input int k);
      case (k)
         0:  return 536870912;
         1:  return 316933406;
         2:  return 167458907;
         3:  return 85004756;
         4:  return 42667331;
         5:  return 21354465;
         6:  return 10679838;
         7:  return 5340245;
         8:  return 2670163;
         9:  return 1335087;
         10: return 667544;
         11: return 333772;
         12: return 166886;
         13: return 83443;
         14: return 41722;
         15: return 20861;
         16: return 10430;
         17: return 5215;
         18: return 2608;
         19: return 1304;
         20: return 652;
         21: return 326;
         22: return 163;
         23: return 81;
         default: return 0;
      endcase
   endfunction

   function automatic polar_result_type predict_correction(input polar_request_type r);
      longint           x, y, z, t, a, dx, dy;
      polar_result_type res;
      x = longint'(r.magnitude) <<< GUARD;
      y = 0;
      a = $signed(r.angle);
      dx = $signed(r.delta_x);
      dy = $signed(r.delta_y);
      // fold into [-pi/2, pi/2]; -pi lands on zero with x negated
      if (a > QUARTER_POS) begin
         x = -x;
         a = a - 32768;
      end else if (a < QUARTER_NEG) begin
         x = -x;
         a = a + 32768;
      end
      z = a <<< 16;
      for (int k = 0; k < STEPS; k++) begin
         if (z >= 0) begin
            t = x - (y >>> k);
            y = y + (x >>> k);
            z = z - arctan_step(k);
         end else begin
            t = x + (y >>> k);
            y = y - (x >>> k);
            z = z + arctan_step(k);
         end
         x = t;
      end
      x = (x * GAIN_Q30 + XY_ROUND) >>> 30;
      y = (y * GAIN_Q30 + XY_ROUND) >>> 30;
      x = x + (dx <<< GUARD);
      y = y + (dy <<< GUARD);
      res = '0;
      if (x == 0 && y == 0)
         return res;
      z = 0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 64'sd2147483648;
      end
      for (int k = 0; k < STEPS; k++) begin
         if (y >= 0) begin
            t = x + (y >>> k);
            y = y - (x >>> k);
            z = z + arctan_step(k);
         end else begin
            t = x - (y >>> k);
            y = y + (x >>> k);
            z = z - arctan_step(k);
         end
         x = t;
      end
      t = (x * GAIN_Q30 + MAG_ROUND) >>> 38;
      if (t < 0)
         t = 0;
      if (t > CMAG_MAX)
         t = CMAG_MAX;
      res.magnitude = t[CMAG_W-1:0];
      z = z + 32768;
      res.angle = z[31:16];
      return res;
   endfunction

   task automatic push_request(input int mag, input int ang, input int dx, input int dy,
                               input bit drain);
      polar_request_type r;
      r.magnitude   = mag[MAG_W-1:0];
      r.angle       = ang[ANG_W-1:0];
      r.delta_x     = dx[DELTA_W-1:0];
      r.delta_y     = dy[DELTA_W-1:0];
      r.drain_first = drain;
      pending_requests.push_back(r);
   endtask

   function automatic int pick_extreme(input int lo, input int hi);
      case ($urandom_range(0, 3))
         0:       return lo;
         1:       return hi;
         2:       return 0;
         default: return int'($urandom_range(0, 2)) - 1;
      endcase
   endfunction

   task automatic push_random(input bit drain);
      int mag, ang, dx, dy, j1, j2;
      mag = $urandom;
      ang = $urandom;
      dx  = $urandom;
      dy  = $urandom;
      j1  = int'($urandom_range(0, 4)) - 2;
      j2  = int'($urandom_range(0, 4)) - 2;
      case ($urandom_range(0, 7))
         0, 1, 2: ;   // fully random fields
         3: begin
            mag = $urandom_range(0, 255);
            dx  = int'($urandom_range(0, 511)) - 256;
            dy  = int'($urandom_range(0, 511)) - 256;
         end
         4: begin
            // tiny offsets alone: zero sum, axis and negative-x cases
            mag = 0;
            dx  = int'($urandom_range(0, 6)) - 3;
            dy  = int'($urandom_range(0, 6)) - 3;
         end
         5: begin
            case ($urandom_range(0, 4))
               0:       ang = -32768;
               1:       ang = 32767;
               2:       ang = 16384 + int'($urandom_range(0, 2)) - 1;
               3:       ang = -16384 + int'($urandom_range(0, 2)) - 1;
               default: ang = int'($urandom_range(0, 2)) - 1;
            endcase
            if ($urandom_range(0, 1) == 0) begin
               dx = 0;
               dy = 0;
            end
         end
         6: begin
            // offset nearly cancels the vector
            mag = $urandom_range(0, 1048000);
            case ($urandom_range(0, 3))
               0: begin ang = 0;      dx = -mag + j1; dy = j2;        end
               1: begin ang = 16384;  dx = j1;        dy = -mag + j2; end
               2: begin ang = -32768; dx = mag + j1;  dy = j2;        end
               default: begin ang = -16384; dx = j1;  dy = mag + j2;  end
            endcase
         end
         default: begin
            mag = pick_extreme(0, MAG_MAX);
            ang = pick_extreme(-32768, 32767);
            dx  = pick_extreme(DELTA_MIN, DELTA_MAX);
            dy  = pick_extreme(DELTA_MIN, DELTA_MAX);
         end
      endcase
      push_request(mag, ang, dx, dy, drain);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_polar.push_back(predict_correction(in_flight));
            requests_sent++;
         end
         if (!(req_valid && !req_ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (requests_sent < total_requests - QUIET_TAIL &&
                         (requests_sent / 150) % 3 != 2 && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(0, 3);
               req_valid <= 1'b0;
            end else if (pending_requests.size() == 0 ||
                         (pending_requests[0].drain_first && expected_polar.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               in_flight = pending_requests.pop_front();
               req_magnitude <= in_flight.magnitude;
               req_angle     <= in_flight.angle;
               req_delta_x   <= in_flight.delta_x;
               req_delta_y   <= in_flight.delta_y;
               req_valid     <= 1'b1;
            end
         end
      end
   end

   // result-side ready: random stall bursts plus one long hold-off to back up the pipe
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rx_cycles++;
         if (rx_cycles == HOLD_START)
            hold_left = HOLD_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (results_seen < total_requests - QUIET_TAIL &&
                      (rx_cycles / 500) % 3 != 2 && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_polar.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: magnitude %0d angle %0d",
                        rsp_corrected_magnitude, rsp_corrected_angle);
         end else begin
            want = expected_polar.pop_front();
            if (rsp_corrected_magnitude !== want.magnitude ||
                rsp_corrected_angle !== want.angle) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("beat %0d: expected magnitude %0d angle %0d, got magnitude %0d angle %0d",
                           results_seen, want.magnitude, want.angle,
                           rsp_corrected_magnitude, rsp_corrected_angle);
            end
         end
         results_seen++;
      end
   end

   initial begin
      // directed beats
      push_request(0, 0, 0, 0, 1'b0);                           // zero sum
      push_request(0, 32767, 0, 0, 1'b0);                       // zero sum, nonzero angle
      push_request(MAG_MAX, 0, 0, 0, 1'b0);
      push_request(MAG_MAX, -32768, 0, 0, 1'b0);                // minus pi taken as pi
      push_request(MAG_MAX, 32767, 0, 0, 1'b0);
      push_request(MAG_MAX, 16384, 0, 0, 1'b0);
      push_request(MAG_MAX, -16384, 0, 0, 1'b0);
      push_request(MAG_MAX, 16385, 0, 0, 1'b0);
      push_request(MAG_MAX, -16385, 0, 0, 1'b0);
      push_request(0, 0, DELTA_MAX, DELTA_MAX, 1'b0);
      push_request(0, 0, DELTA_MIN, DELTA_MIN, 1'b0);
      push_request(MAG_MAX, 8192, DELTA_MAX, DELTA_MAX, 1'b0);  // near the largest corrected magnitude
      push_request(MAG_MAX, -24576, DELTA_MIN, DELTA_MIN, 1'b0);
      push_request(0, 0, -1, 0, 1'b0);                          // negative x axis
      push_request(0, 0, 0, 1, 1'b0);
      push_request(0, 0, 0, -1, 1'b0);
      push_request(1, 0, -1, 0, 1'b0);
      push_request(64, 12345, 21'h0AAAAA, 21'h155555, 1'b0);
      push_request(20'h55555, 16'hAAAA, 21'h155555, 21'h0AAAAA, 1'b0);
      push_request(20'hAAAAA, 16'h5555, 0, 0, 1'b0);
      push_request(MAG_MAX, 0, DELTA_MIN, 0, 1'b0);
      push_request(MAG_MAX, -32768, DELTA_MAX, 0, 1'b0);
      for (int n = 0; n < RANDOM_BEATS; n++)
         push_random(n == 0 || n == RANDOM_BEATS / 2);
      total_requests = pending_requests.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid || expected_polar.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 16) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #1000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
